// ----- sv/assert_macros.svh -----
// Assertion macros shared by the span allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define BFPSA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off during reset.
`define BFPSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/bfpsa_pkg.sv -----
// Types and constants of the best-fit page span allocator.
`default_nettype none
package bfpsa_pkg;

    localparam int ADDR_W  = 12;
    localparam int LEN_W   = 13;
    localparam int START_W = 16;
    localparam int AGE_W   = 16;
    localparam int STAT_W  = 2;

    localparam logic [LEN_W-1:0] LEN_MAX         = 13'h1FFF;
    localparam logic [LEN_W-1:0] POOL_LIMIT_INIT = 13'd4096;

    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
    localparam logic [STAT_W-1:0] ST_EXHAUSTED  = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNKNOWN    = 2'd2;
    localparam logic [STAT_W-1:0] ST_TABLE_FULL = 2'd3;

    typedef struct packed {
        logic              mode;
        logic [LEN_W-1:0]  page_count;
        logic [ADDR_W-1:0] page_addr;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] granted_addr;
        logic [STAT_W-1:0] status;
    } rsp_t;

endpackage
`default_nettype wire

// ----- sv/best_fit_page_span_allocator_unit.sv -----
// Top level of the best-fit page span allocator with successor coalescing.
`default_nettype none
`include "assert_macros.svh"
// Best-fit page span allocator. One transaction on the s_ channel is either an
// allocate (mode 0) or a release (mode 1); each gives exactly one transaction
// on the m_ channel with the granted first page and a status code. Span start,
// length and age live in three small RAMs that one sequencer walks one entry
// per cycle; the per-entry valid, registered and free flags are flip-flops.
// A release takes one table walk. A granted allocate takes a best-fit walk,
// then a second walk that retires stale registrations of the granted start
// page. A refused allocate skips the second walk, like a release. Both walks
// share the RAM read port. The block takes no new transaction while one is
// in flight; a finished result sits in the output register until taken, and
// the block reports ready again as soon as it is there. pool_limit is written
// through cfg_wr_en / cfg_wr_data; the user must write it only while idle,
// which the block itself does not enforce. The fresh region is bounded by
// min(pool_limit, POOL_PAGES). No clearing pass is needed after reset.
module best_fit_page_span_allocator_unit #(
    parameter int POOL_PAGES   = 4096,
    parameter int SPAN_ENTRIES = 64
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [bfpsa_pkg::LEN_W-1:0]   cfg_wr_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire bfpsa_pkg::req_t               s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output bfpsa_pkg::rsp_t                    m_data
);

    localparam int IDX_W = $clog2(SPAN_ENTRIES);
    localparam int CNT_W = $clog2(SPAN_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(SPAN_ENTRIES);
    localparam logic [16:0]      POOL_LIM = 17'(POOL_PAGES);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_WRITE2, S_REG, S_RESULT
    } state_t;

    localparam int LW = bfpsa_pkg::LEN_W;
    localparam int SW = bfpsa_pkg::START_W;
    localparam int AW = bfpsa_pkg::AGE_W;

    state_t               state_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 eval_vld_reg;
    logic [IDX_W-1:0]     eval_idx_reg;
    bfpsa_pkg::req_t      req_reg;
    logic [LW-1:0]        pool_limit_reg;
    logic [LW-1:0]        fresh_mark_reg;
    logic [AW-1:0]        age_ctr_reg;
    logic [SPAN_ENTRIES-1:0] valid_reg, regd_reg, free_reg;

    // best-fit and empty-slot trackers
    logic                 best_found_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic [LW-1:0]        best_len_reg;
    logic [AW-1:0]        best_dist_reg;
    logic [SW-1:0]        best_start_reg;
    logic                 empty_found_reg;
    logic [IDX_W-1:0]     empty_idx_reg;

    // release trackers: owner entry and first two successor candidates
    logic                 e_found_reg, n1_found_reg, n2_found_reg;
    logic [IDX_W-1:0]     e_idx_reg, n1_idx_reg, n2_idx_reg;
    logic [LW-1:0]        e_len_reg, n1_len_reg, n2_len_reg;

    // registration pass target
    logic [SW-1:0]        reg_start_reg;
    logic [IDX_W-1:0]     reg_idx_reg;

    logic [bfpsa_pkg::ADDR_W-1:0] res_addr_reg;
    logic [bfpsa_pkg::STAT_W-1:0] res_status_reg;
    logic                 m_valid_reg;
    bfpsa_pkg::rsp_t      m_data_reg;

    // RAM ports
    logic [IDX_W-1:0] raddr;
    logic [SW-1:0]    rd_start;
    logic [LW-1:0]    rd_len;
    logic [AW-1:0]    rd_age;
    logic             start_we, len_we, age_we;
    logic [IDX_W-1:0] start_wa, len_wa, age_wa;
    logic [SW-1:0]    start_wd;
    logic [LW-1:0]    len_wd;

    assign raddr = cnt_reg[IDX_W-1:0];

    bfpsa_ram #(.WIDTH(SW), .DEPTH(SPAN_ENTRIES)) u_start_ram (
        .aclk(aclk), .we(start_we), .waddr(start_wa), .wdata(start_wd),
        .raddr(raddr), .rdata(rd_start)
    );
    bfpsa_ram #(.WIDTH(LW), .DEPTH(SPAN_ENTRIES)) u_len_ram (
        .aclk(aclk), .we(len_we), .waddr(len_wa), .wdata(len_wd),
        .raddr(raddr), .rdata(rd_len)
    );
    bfpsa_ram #(.WIDTH(AW), .DEPTH(SPAN_ENTRIES)) u_age_ram (
        .aclk(aclk), .we(age_we), .waddr(age_wa), .wdata(age_ctr_reg),
        .raddr(raddr), .rdata(rd_age)
    );

    // Per-entry evaluation of the word just read.
    logic          ev_v, ev_r, ev_f;
    logic [AW-1:0] ev_dist;
    logic [SW-1:0] next_addr;
    logic          a_better, a_empty, r_own, r_succ, g_hit;

    always_comb begin
        ev_v      = eval_vld_reg & valid_reg[eval_idx_reg];
        ev_r      = regd_reg[eval_idx_reg];
        ev_f      = free_reg[eval_idx_reg];
        ev_dist   = age_ctr_reg - rd_age;
        next_addr = SW'(req_reg.page_addr) + SW'(req_reg.page_count);
        a_better  = ev_v & ev_f & (rd_len >= req_reg.page_count) &
                    (!best_found_reg || (rd_len < best_len_reg) ||
                     ((rd_len == best_len_reg) && (ev_dist < best_dist_reg)));
        a_empty   = eval_vld_reg & !valid_reg[eval_idx_reg] & !empty_found_reg;
        r_own     = ev_v & ev_r & (rd_start == SW'(req_reg.page_addr)) & !e_found_reg;
        r_succ    = ev_v & ev_r & ev_f & (rd_start == next_addr);
        g_hit     = ev_v & ev_r & (rd_start == reg_start_reg) &
                    (eval_idx_reg != reg_idx_reg);
    end

    // Decision after the first walk.
    logic [16:0]      limit;
    logic             fresh_bad, split, nxt_found, dec_ok;
    logic [IDX_W-1:0] nxt_idx;
    logic [LW-1:0]    nxt_len;
    logic [LW:0]      merge_sum;
    logic [bfpsa_pkg::STAT_W-1:0] dec_status;

    always_comb begin
        limit     = (17'(pool_limit_reg) < POOL_LIM) ? 17'(pool_limit_reg) : POOL_LIM;
        fresh_bad = (17'(fresh_mark_reg) > limit) ||
                    (17'(req_reg.page_count) > (limit - 17'(fresh_mark_reg)));
        split     = best_len_reg > req_reg.page_count;
        if (n1_found_reg && (n1_idx_reg != e_idx_reg)) begin
            nxt_found = 1'b1;
            nxt_idx   = n1_idx_reg;
            nxt_len   = n1_len_reg;
        end else begin
            nxt_found = n2_found_reg;
            nxt_idx   = n2_idx_reg;
            nxt_len   = n2_len_reg;
        end
        merge_sum = (LW+1)'(e_len_reg) + (LW+1)'(nxt_len);

        dec_status = bfpsa_pkg::ST_OK;
        if (req_reg.mode == bfpsa_pkg::MODE_RELEASE) begin
            if (!e_found_reg) dec_status = bfpsa_pkg::ST_UNKNOWN;
        end else if (req_reg.page_count == '0) begin
            dec_status = bfpsa_pkg::ST_EXHAUSTED;
        end else if (best_found_reg) begin
            if (split && !empty_found_reg) dec_status = bfpsa_pkg::ST_TABLE_FULL;
        end else if (fresh_bad) begin
            dec_status = bfpsa_pkg::ST_EXHAUSTED;
        end else if (!empty_found_reg) begin
            dec_status = bfpsa_pkg::ST_TABLE_FULL;
        end
        dec_ok = (dec_status == bfpsa_pkg::ST_OK);

        start_we = 1'b0; start_wa = empty_idx_reg; start_wd = '0;
        len_we   = 1'b0; len_wa   = empty_idx_reg; len_wd   = '0;
        age_we   = 1'b0; age_wa   = empty_idx_reg;
        if (state_reg == S_DECIDE && dec_ok) begin
            if (req_reg.mode == bfpsa_pkg::MODE_RELEASE) begin
                len_we = nxt_found;
                len_wa = e_idx_reg;
                len_wd = (merge_sum > (LW+1)'(bfpsa_pkg::LEN_MAX)) ?
                         bfpsa_pkg::LEN_MAX : merge_sum[LW-1:0];
                age_we = 1'b1;
                age_wa = e_idx_reg;
            end else if (best_found_reg) begin
                // remainder of a split goes to the empty slot
                start_we = split;
                start_wd = best_start_reg + SW'(req_reg.page_count);
                len_we   = split;
                len_wd   = best_len_reg - req_reg.page_count;
                age_we   = split;
            end else begin
                start_we = 1'b1;
                start_wd = SW'(fresh_mark_reg);
                len_we   = 1'b1;
                len_wd   = req_reg.page_count;
                age_we   = 1'b1;
            end
        end else if (state_reg == S_WRITE2) begin
            len_we = 1'b1;
            len_wa = best_idx_reg;
            len_wd = req_reg.page_count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            eval_vld_reg   <= 1'b0;
            pool_limit_reg <= bfpsa_pkg::POOL_LIMIT_INIT;
            fresh_mark_reg <= '0;
            age_ctr_reg    <= '0;
            valid_reg      <= '0;
            regd_reg       <= '0;
            free_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) pool_limit_reg <= cfg_wr_data;
            // S_RESULT reloads the output register itself
            if (m_valid_reg && m_ready && (state_reg != S_RESULT)) m_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        req_reg         <= s_data;
                        cnt_reg         <= '0;
                        eval_vld_reg    <= 1'b0;
                        best_found_reg  <= 1'b0;
                        empty_found_reg <= 1'b0;
                        e_found_reg     <= 1'b0;
                        n1_found_reg    <= 1'b0;
                        n2_found_reg    <= 1'b0;
                        state_reg       <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (a_better) begin
                        best_found_reg <= 1'b1;
                        best_idx_reg   <= eval_idx_reg;
                        best_len_reg   <= rd_len;
                        best_dist_reg  <= ev_dist;
                        best_start_reg <= rd_start;
                    end
                    if (a_empty) begin
                        empty_found_reg <= 1'b1;
                        empty_idx_reg   <= eval_idx_reg;
                    end
                    if (r_own) begin
                        e_found_reg <= 1'b1;
                        e_idx_reg   <= eval_idx_reg;
                        e_len_reg   <= rd_len;
                    end
                    if (r_succ && !n1_found_reg) begin
                        n1_found_reg <= 1'b1;
                        n1_idx_reg   <= eval_idx_reg;
                        n1_len_reg   <= rd_len;
                    end else if (r_succ && !n2_found_reg) begin
                        n2_found_reg <= 1'b1;
                        n2_idx_reg   <= eval_idx_reg;
                        n2_len_reg   <= rd_len;
                    end
                    if (cnt_reg != CNT_END) begin
                        eval_vld_reg <= 1'b1;
                        eval_idx_reg <= cnt_reg[IDX_W-1:0];
                        cnt_reg      <= cnt_reg + 1'b1;
                    end else begin
                        eval_vld_reg <= 1'b0;
                        state_reg    <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    res_status_reg <= dec_status;
                    res_addr_reg   <= '0;
                    cnt_reg        <= '0;
                    state_reg      <= S_RESULT;
                    if (dec_ok) begin
                        if (req_reg.mode == bfpsa_pkg::MODE_RELEASE) begin
                            if (nxt_found) begin
                                valid_reg[nxt_idx] <= 1'b0;
                                regd_reg[nxt_idx]  <= 1'b0;
                                free_reg[nxt_idx]  <= 1'b0;
                            end
                            free_reg[e_idx_reg] <= 1'b1;
                            age_ctr_reg         <= age_ctr_reg + 1'b1;
                        end else if (best_found_reg) begin
                            free_reg[best_idx_reg] <= 1'b0;
                            reg_start_reg          <= best_start_reg;
                            reg_idx_reg            <= best_idx_reg;
                            res_addr_reg <= best_start_reg[bfpsa_pkg::ADDR_W-1:0];
                            if (split) begin
                                valid_reg[empty_idx_reg] <= 1'b1;
                                free_reg[empty_idx_reg]  <= 1'b1;
                                regd_reg[empty_idx_reg]  <= 1'b0;
                                age_ctr_reg              <= age_ctr_reg + 1'b1;
                                state_reg                <= S_WRITE2;
                            end else begin
                                state_reg <= S_REG;
                            end
                        end else begin
                            valid_reg[empty_idx_reg] <= 1'b1;
                            free_reg[empty_idx_reg]  <= 1'b0;
                            regd_reg[empty_idx_reg]  <= 1'b0;
                            age_ctr_reg              <= age_ctr_reg + 1'b1;
                            fresh_mark_reg <= fresh_mark_reg + req_reg.page_count;
                            reg_start_reg  <= SW'(fresh_mark_reg);
                            reg_idx_reg    <= empty_idx_reg;
                            res_addr_reg   <= fresh_mark_reg[bfpsa_pkg::ADDR_W-1:0];
                            state_reg      <= S_REG;
                        end
                    end
                end
                S_WRITE2: begin
                    state_reg <= S_REG;
                end
                S_REG: begin
                    // retire older registrations of the same start page
                    if (g_hit) begin
                        regd_reg[eval_idx_reg] <= 1'b0;
                        if (!free_reg[eval_idx_reg]) valid_reg[eval_idx_reg] <= 1'b0;
                    end
                    if (cnt_reg != CNT_END) begin
                        eval_vld_reg <= 1'b1;
                        eval_idx_reg <= cnt_reg[IDX_W-1:0];
                        cnt_reg      <= cnt_reg + 1'b1;
                    end else begin
                        eval_vld_reg          <= 1'b0;
                        regd_reg[reg_idx_reg] <= 1'b1;
                        state_reg             <= S_RESULT;
                    end
                end
                S_RESULT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg             <= 1'b1;
                        m_data_reg.granted_addr <= res_addr_reg;
                        m_data_reg.status       <= res_status_reg;
                        state_reg               <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `BFPSA_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "accepted while busy")
    `BFPSA_ASSERT_NOW(a_fail_addr_zero, m_valid && (m_data.status != bfpsa_pkg::ST_OK), m_data.granted_addr == '0, "failed transaction with nonzero address")
    `BFPSA_ASSERT_NEXT(a_fresh_mono, 1'b1, fresh_mark_reg >= $past(fresh_mark_reg), "fresh mark went back")
    `BFPSA_ASSERT_NEXT(a_age_step, 1'b1, (age_ctr_reg == $past(age_ctr_reg)) || (age_ctr_reg == 16'($past(age_ctr_reg) + 16'd1)), "age counter jumped")

endmodule
`default_nettype wire

// ----- sv/bfpsa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bfpsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire
